### hw/rtl/sensor_input_conditioner_defines.svh
`ifndef SENSOR_INPUT_CONDITIONER_DEFINES_SVH
`define SENSOR_INPUT_CONDITIONER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SIC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SIC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/sic_pkg.sv
package sic_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_ADC,
    ST_MUL,
    ST_DIV,
    ST_ASGN,
    ST_FIX,
    ST_DONE
  } sic_state_t;

  localparam logic [2:0] MODE_DIN     = 3'd0;
  localparam logic [2:0] MODE_COUNTER = 3'd1;
  localparam logic [2:0] MODE_TIMER   = 3'd2;
  localparam logic [2:0] MODE_RATE    = 3'd3;
  localparam logic [2:0] MODE_ADC     = 3'd4;

  localparam logic [2:0] REG_MODE     = 3'd0;
  localparam logic [2:0] REG_OFFSET   = 3'd1;
  localparam logic [2:0] REG_FACTOR   = 3'd2;
  localparam logic [2:0] REG_DEBOUNCE = 3'd3;
  localparam logic [2:0] REG_INTERVAL = 3'd4;

  localparam logic signed [31:0] FACTOR_RESET   = 32'sd65536;
  localparam logic [15:0]        DEBOUNCE_RESET = 16'd15;
  localparam logic [15:0]        INTERVAL_RESET = 16'd500;

  localparam logic signed [47:0] VAL_MAX     = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] VAL_MIN     = 48'sh8000_0000_0000;
  localparam logic signed [47:0] DIGITAL_ONE = 48'sd65536;
  localparam logic [31:0]        MS_PER_S    = 32'd1000;

  localparam int DIV_STEPS = 64;

endpackage

### hw/rtl/sensor_input_conditioner.sv
// Conditions one sensor input per poll item and returns one result item per poll. Digital-in,
// counter, unused modes, ADC polls that take no sample and rate edges with a zero interval go
// from EVAL straight to DONE, where the result register loads; an ADC sample that leaves the
// reading in place passes EVAL and ADC, an ADC update passes EVAL, ADC, MUL and ASGN through
// the shared 32x32 multiplier, and a timer or rate edge passes EVAL, MUL, the 64-step restoring
// divider DIV that follows the multiplier, and FIX. A finished item waits while the previous
// result is still pending; the next poll is taken in the cycle after the result register loads.
`include "sensor_input_conditioner_defines.svh"

module sensor_input_conditioner
  import sic_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               poll_valid,
  output logic               poll_ready,
  input  logic [31:0]        now_ms,
  input  logic               pin_level,
  input  logic [11:0]        adc_mv,
  output logic               result_valid,
  input  logic               result_ready,
  output logic signed [47:0] sensor_value,
  output logic               changed,
  output logic [11:0]        filtered_mv
);

  logic [2:0]         mode;
  logic signed [12:0] adc_offset;
  logic signed [31:0] scale_factor;
  logic [15:0]        debounce_ms;
  logic [15:0]        adc_interval_ms;

  logic [31:0] now_q;
  logic        pin_q;
  logic [11:0] adc_q;

  logic signed [47:0] held_value;
  logic               raw_level;
  logic [12:0]        stable_level;
  logic [31:0]        change_time;
  logic [31:0]        last_edge_time;
  logic [21:0]        filter_sum;
  logic [12:0]        filter_avg;
  logic [31:0]        last_sample_time;
  logic               not_sampled;

  logic [63:0] acc;
  logic [31:0] rem;
  logic [31:0] divisor;
  logic [31:0] mul_b;
  logic [5:0]  div_cnt;
  logic        neg;
  logic        chg;

  sic_state_t state, state_next;
  logic       out_load;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode            <= MODE_DIN;
      adc_offset      <= '0;
      scale_factor    <= FACTOR_RESET;
      debounce_ms     <= DEBOUNCE_RESET;
      adc_interval_ms <= INTERVAL_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[4:2])
        REG_MODE:     mode            <= pwdata[2:0];
        REG_OFFSET:   adc_offset      <= pwdata[12:0];
        REG_FACTOR:   scale_factor    <= pwdata;
        REG_DEBOUNCE: debounce_ms     <= pwdata[15:0];
        REG_INTERVAL: adc_interval_ms <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_MODE:     prdata = {29'd0, mode};
      REG_OFFSET:   prdata = {{19{adc_offset[12]}}, adc_offset};
      REG_FACTOR:   prdata = scale_factor;
      REG_DEBOUNCE: prdata = {16'd0, debounce_ms};
      REG_INTERVAL: prdata = {16'd0, adc_interval_ms};
      default:      prdata = '0;
    endcase
  end

  logic [31:0] fac_mag;
  logic        sample_fire;
  logic [30:0] sum_x511;
  logic [21:0] sum_new;
  logic [31:0] ct_new;
  logic        level_ok;
  logic [31:0] interval;
  logic [48:0] cnt_sum;
  logic [47:0] cnt_sat;
  logic [13:0] stable_p1;
  logic [13:0] avg_p1;
  logic        adc_move;
  logic [14:0] diff;
  logic [14:0] diff_mag;
  logic [32:0] rem_shift;
  logic        sub_ok;
  logic [47:0] fix_val;

  always_comb begin
    fac_mag     = scale_factor[31] ? (~scale_factor + 32'd1) : scale_factor;
    sample_fire = not_sampled || ((now_q - last_sample_time) >= {16'd0, adc_interval_ms});
    sum_x511    = {filter_sum, 9'd0} - {9'd0, filter_sum};
    sum_new     = sum_x511[30:9] + {10'd0, adc_q};
    ct_new      = (raw_level != pin_q) ? now_q : change_time;
    level_ok    = ((now_q - ct_new) >= {16'd0, debounce_ms})
                  && ({12'd0, pin_q} != stable_level);
    interval    = ct_new - last_edge_time;
    cnt_sum     = {held_value[47], held_value} + {{17{scale_factor[31]}}, scale_factor};
    if (cnt_sum[48] != cnt_sum[47]) begin
      cnt_sat = cnt_sum[48] ? VAL_MIN : VAL_MAX;
    end else begin
      cnt_sat = cnt_sum[47:0];
    end
    stable_p1 = {1'b0, stable_level} + 14'd1;
    avg_p1    = {1'b0, filter_avg} + 14'd1;
    adc_move  = (stable_p1 < {1'b0, filter_avg}) || ({1'b0, stable_level} > avg_p1);
    diff      = {2'b00, filter_avg} - {{2{adc_offset[12]}}, adc_offset};
    diff_mag  = diff[14] ? (~diff + 15'd1) : diff;
    rem_shift = {rem, acc[63]};
    sub_ok    = rem_shift >= {1'b0, divisor};
    if (neg) begin
      fix_val = (acc > 64'h0000_8000_0000_0000) ? VAL_MIN : (~acc[47:0] + 48'd1);
    end else begin
      fix_val = (acc > 64'h0000_7FFF_FFFF_FFFF) ? VAL_MAX : acc[47:0];
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (poll_valid) state_next = ST_EVAL;
      ST_EVAL: begin
        if (mode == MODE_ADC) begin
          state_next = sample_fire ? ST_ADC : ST_DONE;
        end else if (!mode[2] && level_ok && !pin_q
                     && (mode == MODE_TIMER || (mode == MODE_RATE && interval != 32'd0))) begin
          state_next = ST_MUL;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_ADC:  state_next = adc_move ? ST_MUL : ST_DONE;
      ST_MUL:  state_next = (mode == MODE_ADC) ? ST_ASGN : ST_DIV;
      ST_DIV:  if (div_cnt == 6'(DIV_STEPS - 1)) state_next = ST_FIX;
      ST_ASGN: state_next = ST_DONE;
      ST_FIX:  state_next = ST_DONE;
      ST_DONE: if (out_load) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    poll_ready = (state == ST_IDLE);
    out_load   = (state == ST_DONE) && (!result_valid || result_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      result_valid     <= 1'b0;
      held_value       <= '0;
      raw_level        <= 1'b1;
      stable_level     <= '0;
      change_time      <= '0;
      last_edge_time   <= '0;
      filter_sum       <= '0;
      filter_avg       <= '0;
      last_sample_time <= '0;
      not_sampled      <= 1'b1;
    end else begin
      state <= state_next;
      if (out_load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (poll_valid) begin
            now_q <= now_ms;
            pin_q <= pin_level;
            adc_q <= adc_mv;
            chg   <= 1'b0;
          end
        end
        ST_EVAL: begin
          if (sample_fire) begin
            last_sample_time <= now_q;
            not_sampled      <= 1'b0;
            if (mode == MODE_ADC) begin
              if (filter_avg == 13'd0) begin
                filter_avg <= {1'b0, adc_q};
                filter_sum <= {1'b0, adc_q, 9'd0};
              end else begin
                filter_sum <= sum_new;
                filter_avg <= sum_new[21:9];
              end
            end
          end
          if (!mode[2]) begin
            raw_level   <= pin_q;
            change_time <= ct_new;
            if (level_ok) begin
              stable_level <= {12'd0, pin_q};
              if (mode == MODE_DIN) begin
                held_value <= pin_q ? DIGITAL_ONE : '0;
                chg        <= (pin_q ? DIGITAL_ONE : 48'sd0) != held_value;
              end else if (!pin_q) begin
                last_edge_time <= ct_new;
                neg            <= scale_factor[31];
                if (mode == MODE_COUNTER) begin
                  held_value <= cnt_sat;
                  chg        <= cnt_sat != held_value;
                end else if (mode == MODE_RATE) begin
                  if (interval == 32'd0) begin
                    held_value <= VAL_MAX;
                    chg        <= held_value != VAL_MAX;
                  end
                  mul_b   <= MS_PER_S;
                  divisor <= interval;
                end else begin
                  mul_b   <= interval;
                  divisor <= MS_PER_S;
                end
              end
            end
          end
        end
        ST_ADC: begin
          if (adc_move) begin
            stable_level <= filter_avg;
            mul_b        <= {17'd0, diff_mag};
            neg          <= diff[14] ^ scale_factor[31];
          end
        end
        ST_MUL: begin
          acc     <= fac_mag * mul_b;
          rem     <= '0;
          div_cnt <= '0;
        end
        ST_DIV: begin
          rem     <= sub_ok ? 32'(rem_shift - {1'b0, divisor}) : rem_shift[31:0];
          acc     <= {acc[62:0], sub_ok};
          div_cnt <= div_cnt + 6'd1;
        end
        ST_ASGN: begin
          held_value <= neg ? (~acc[47:0] + 48'd1) : acc[47:0];
          chg        <= 1'b1;
        end
        ST_FIX: begin
          held_value <= fix_val;
          chg        <= fix_val != held_value;
        end
        ST_DONE: begin
          if (out_load) begin
            sensor_value <= held_value;
            changed      <= chg;
            filtered_mv  <= filter_avg[11:0];
          end
        end
        default: ;
      endcase
    end
  end

  `SIC_ASSERT_SAME(a_filter_avg_tracks_sum, 1'b1, filter_avg == filter_sum[21:9],
                   "filter average out of step with filter sum")
  `SIC_ASSERT_SAME(a_div_rem_below_divisor, state == ST_DIV, rem < divisor,
                   "divider remainder not below divisor")
  `SIC_ASSERT_NEXT(a_pending_result_kept, (state == ST_DONE) && result_valid && !result_ready,
                   (state == ST_DONE) && result_valid,
                   "finished item left while previous result was pending")

endmodule
